### hdl/a64_instruction_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// A64 instruction encoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i with reset disable.
// ----------------------------------------------------------------------------
`ifndef A64_INSTRUCTION_ENCODER_TOP_DEFINES_SVH
`define A64_INSTRUCTION_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define A64E_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define A64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/a64enc_pkg.sv
// ----------------------------------------------------------------------------
// A64 encoder package
// Mnemonic codes, field widths and constants of the A64 instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package a64enc_pkg;

  localparam int unsigned OpW    = 6;
  localparam int unsigned RegW   = 5;
  localparam int unsigned ImmW   = 32;
  localparam int unsigned StW    = 2;
  localparam int unsigned AmtW   = 6;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 30;
  localparam int unsigned TdataW = 64;

  localparam logic [RegW-1:0]  ZeroReg      = 5'd31;
  localparam logic [31:0]      NopWord      = 32'hD503201F;
  localparam logic [15:0]      BrTop        = 16'hD61F;
  localparam logic [7:0]       BcondTop     = 8'd84;
  localparam logic [3:0]       RegOffOption = 4'd13;

  // mnemonic codes
  localparam logic [OpW-1:0] OP_ADD_IMM  = 6'd0;
  localparam logic [OpW-1:0] OP_ADDS_IMM = 6'd1;
  localparam logic [OpW-1:0] OP_SUB_IMM  = 6'd2;
  localparam logic [OpW-1:0] OP_SUBS_IMM = 6'd3;
  localparam logic [OpW-1:0] OP_ADD_REG  = 6'd4;
  localparam logic [OpW-1:0] OP_ADDS_REG = 6'd5;
  localparam logic [OpW-1:0] OP_SUB_REG  = 6'd6;
  localparam logic [OpW-1:0] OP_SUBS_REG = 6'd7;
  localparam logic [OpW-1:0] OP_CMP_IMM  = 6'd8;
  localparam logic [OpW-1:0] OP_CMN_IMM  = 6'd9;
  localparam logic [OpW-1:0] OP_CMP_REG  = 6'd10;
  localparam logic [OpW-1:0] OP_CMN_REG  = 6'd11;
  localparam logic [OpW-1:0] OP_NEG_IMM  = 6'd12;
  localparam logic [OpW-1:0] OP_NEGS_IMM = 6'd13;
  localparam logic [OpW-1:0] OP_NEG_REG  = 6'd14;
  localparam logic [OpW-1:0] OP_NEGS_REG = 6'd15;
  localparam logic [OpW-1:0] OP_AND      = 6'd16;
  localparam logic [OpW-1:0] OP_BIC      = 6'd17;
  localparam logic [OpW-1:0] OP_ORR      = 6'd18;
  localparam logic [OpW-1:0] OP_ORN      = 6'd19;
  localparam logic [OpW-1:0] OP_EOR      = 6'd20;
  localparam logic [OpW-1:0] OP_EON      = 6'd21;
  localparam logic [OpW-1:0] OP_ANDS     = 6'd22;
  localparam logic [OpW-1:0] OP_BICS     = 6'd23;
  localparam logic [OpW-1:0] OP_TST      = 6'd24;
  localparam logic [OpW-1:0] OP_MOVN     = 6'd25;
  localparam logic [OpW-1:0] OP_MOVZ     = 6'd26;
  localparam logic [OpW-1:0] OP_MOVK     = 6'd27;
  localparam logic [OpW-1:0] OP_MOV      = 6'd28;
  localparam logic [OpW-1:0] OP_MVN      = 6'd29;
  localparam logic [OpW-1:0] OP_MADD     = 6'd30;
  localparam logic [OpW-1:0] OP_MSUB     = 6'd31;
  localparam logic [OpW-1:0] OP_MUL      = 6'd32;
  localparam logic [OpW-1:0] OP_MNEG     = 6'd33;
  localparam logic [OpW-1:0] OP_B        = 6'd34;
  localparam logic [OpW-1:0] OP_B_EQ     = 6'd35;
  localparam logic [OpW-1:0] OP_B_NE     = 6'd36;
  localparam logic [OpW-1:0] OP_B_GE     = 6'd37;
  localparam logic [OpW-1:0] OP_B_LT     = 6'd38;
  localparam logic [OpW-1:0] OP_B_GT     = 6'd39;
  localparam logic [OpW-1:0] OP_B_LE     = 6'd40;
  localparam logic [OpW-1:0] OP_B_AL     = 6'd41;
  localparam logic [OpW-1:0] OP_BR       = 6'd42;
  localparam logic [OpW-1:0] OP_LDR_UOFF = 6'd43;
  localparam logic [OpW-1:0] OP_STR_UOFF = 6'd44;
  localparam logic [OpW-1:0] OP_LDR_PRE  = 6'd45;
  localparam logic [OpW-1:0] OP_STR_PRE  = 6'd46;
  localparam logic [OpW-1:0] OP_LDR_POST = 6'd47;
  localparam logic [OpW-1:0] OP_STR_POST = 6'd48;
  localparam logic [OpW-1:0] OP_LDR_ROFF = 6'd49;
  localparam logic [OpW-1:0] OP_STR_ROFF = 6'd50;
  localparam logic [OpW-1:0] OP_LDR_LIT  = 6'd51;
  localparam logic [OpW-1:0] OP_INT      = 6'd52;
  localparam logic [OpW-1:0] OP_NOP      = 6'd53;

  // condition field codes
  localparam logic [4:0] COND_EQ = 5'd0;
  localparam logic [4:0] COND_NE = 5'd1;
  localparam logic [4:0] COND_GE = 5'd10;
  localparam logic [4:0] COND_LT = 5'd11;
  localparam logic [4:0] COND_GT = 5'd12;
  localparam logic [4:0] COND_LE = 5'd13;
  localparam logic [4:0] COND_AL = 5'd14;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic            wide_regs;
    logic [RegW-1:0] first_reg;
    logic [RegW-1:0] second_reg;
    logic [RegW-1:0] third_reg;
    logic [RegW-1:0] fourth_reg;
    logic [ImmW-1:0] immediate;
    logic [StW-1:0]  shift_type;
    logic [AmtW-1:0] shift_amount;
  } item_t;

  function automatic logic [31:0] arith_imm(input logic sf, input logic [1:0] opc,
                                            input logic [4:0] rd, input logic [4:0] rn,
                                            input logic [31:0] imm, input logic [5:0] amt);
    return {sf, opc, 1'b1, 2'b00, 3'b010, (amt != 6'd0), imm[11:0], rn, rd};
  endfunction

  function automatic logic [31:0] dp_reg(input logic sf, input logic [1:0] opc,
                                         input logic [3:0] opr, input logic [4:0] rm,
                                         input logic [5:0] amt, input logic [4:0] rn,
                                         input logic [4:0] rd);
    return {sf, opc, 1'b0, 3'b101, opr, rm, amt, rn, rd};
  endfunction

  function automatic logic [31:0] arith_reg(input logic sf, input logic [1:0] opc,
                                            input logic [4:0] rd, input logic [4:0] rn,
                                            input logic [4:0] rm, input logic [1:0] st,
                                            input logic [5:0] amt);
    return dp_reg(sf, opc, {1'b1, st, 1'b0}, rm, amt, rn, rd);
  endfunction

  // lcode: and, bic, orr, orn, eor, eon, ands, bics
  function automatic logic [31:0] logic_reg(input logic sf, input logic [2:0] lcode,
                                            input logic [4:0] rd, input logic [4:0] rn,
                                            input logic [4:0] rm, input logic [1:0] st,
                                            input logic [5:0] amt);
    return dp_reg(sf, lcode[2:1], {1'b0, st, lcode[0]}, rm, amt, rn, rd);
  endfunction

  function automatic logic [31:0] mul_acc(input logic sf, input logic sub,
                                          input logic [4:0] rd, input logic [4:0] rn,
                                          input logic [4:0] rm, input logic [4:0] ra);
    return {sf, 2'b00, 1'b1, 3'b101, 4'b1000, rm, sub, ra, rn, rd};
  endfunction

endpackage

`default_nettype wire

### hdl/a64_instruction_encoder_top.sv
// ----------------------------------------------------------------------------
// A64 instruction encoder
// The input register holds each instruction; its encoded word is then registered in the result register.
// Throughput: one instruction per cycle while results are taken; encode: two subtracts plus mux.
// A full result register that is not taken stalls only when the input reg is full.
// Reset: asynchronous, clears both valid flags and the instruction counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "a64_instruction_encoder_top_defines.svh"

module a64_instruction_encoder_top
  import a64enc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // wide_regs, first_reg, second_reg, third_reg, fourth_reg, immediate,
  // shift_type, shift_amount, zero pad
  input  wire logic [TdataW-1:0]   s_axis_tdata,
  // opcode
  input  wire logic [OpW-1:0]      s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // machine_word
  output logic [WordW-1:0]         m_axis_tdata
);

  logic              in_valid_q;
  item_t             item_q;
  logic              out_valid_q;
  logic [WordW-1:0]  word_q;
  logic [WordW-1:0]  word_d;
  logic [CountW-1:0] count_q;
  logic              advance;
  logic              in_xfer;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q + CountW'(1);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.opcode       <= s_axis_tuser;
      item_q.wide_regs    <= s_axis_tdata[0];
      item_q.first_reg    <= s_axis_tdata[5:1];
      item_q.second_reg   <= s_axis_tdata[10:6];
      item_q.third_reg    <= s_axis_tdata[15:11];
      item_q.fourth_reg   <= s_axis_tdata[20:16];
      item_q.immediate    <= s_axis_tdata[52:21];
      item_q.shift_type   <= s_axis_tdata[54:53];
      item_q.shift_amount <= s_axis_tdata[60:55];
    end
    if (advance) begin
      word_q <= word_d;
    end
  end

  // encode
  always_comb begin
    logic              sf;
    logic [4:0]        r1;
    logic [4:0]        r2;
    logic [4:0]        r3;
    logic [4:0]        r4;
    logic [31:0]       imm;
    logic [1:0]        st;
    logic [5:0]        amt;
    logic [CountW-1:0] woff;
    logic [2:0]        xop;
    logic [11:0]       xoff;
    logic [4:0]        cond;
    sf   = item_q.wide_regs;
    r1   = item_q.first_reg;
    r2   = item_q.second_reg;
    r3   = item_q.third_reg;
    r4   = item_q.fourth_reg;
    imm  = item_q.immediate;
    st   = item_q.shift_type;
    amt  = item_q.shift_amount;
    // (imm - 4*count) >> 2; low pc bits are zero
    woff = imm[31:2] - count_q;
    xop  = 3'(item_q.opcode - OP_LDR_UOFF);
    if (xop[2:1] == 2'b00) begin
      xoff = sf ? imm[14:3] : imm[13:2];
    end else if (xop[2:1] == 2'b11) begin
      xoff = {1'b1, r3, 1'b0, RegOffOption, 1'b0};
    end else begin
      xoff = {1'b0, imm[8:0], (xop[2:1] == 2'b01), 1'b1};
    end
    case (item_q.opcode)
      OP_B_EQ: cond = COND_EQ;
      OP_B_NE: cond = COND_NE;
      OP_B_GE: cond = COND_GE;
      OP_B_LT: cond = COND_LT;
      OP_B_GT: cond = COND_GT;
      OP_B_LE: cond = COND_LE;
      default: cond = COND_AL;
    endcase
    unique case (item_q.opcode) inside
      OP_ADD_IMM, OP_ADDS_IMM, OP_SUB_IMM, OP_SUBS_IMM: begin
        word_d = arith_imm(sf, item_q.opcode[1:0], r1, r2, imm, amt);
      end
      OP_ADD_REG, OP_ADDS_REG, OP_SUB_REG, OP_SUBS_REG: begin
        word_d = arith_reg(sf, item_q.opcode[1:0], r1, r2, r3, st, amt);
      end
      OP_CMP_IMM:  word_d = arith_imm(sf, 2'd3, ZeroReg, r1, imm, amt);
      OP_CMN_IMM:  word_d = arith_imm(sf, 2'd1, ZeroReg, r1, imm, amt);
      OP_CMP_REG:  word_d = arith_reg(sf, 2'd3, ZeroReg, r1, r2, st, amt);
      OP_CMN_REG:  word_d = arith_reg(sf, 2'd1, ZeroReg, r1, r2, st, amt);
      OP_NEG_IMM:  word_d = arith_imm(sf, 2'd2, r1, ZeroReg, imm, amt);
      OP_NEGS_IMM: word_d = arith_imm(sf, 2'd3, r1, ZeroReg, imm, amt);
      OP_NEG_REG:  word_d = arith_reg(sf, 2'd2, r1, ZeroReg, r2, st, amt);
      OP_NEGS_REG: word_d = arith_reg(sf, 2'd3, r1, ZeroReg, r2, st, amt);
      OP_AND, OP_BIC, OP_ORR, OP_ORN, OP_EOR, OP_EON, OP_ANDS, OP_BICS: begin
        word_d = logic_reg(sf, item_q.opcode[2:0], r1, r2, r3, st, amt);
      end
      OP_TST: word_d = logic_reg(sf, 3'd6, ZeroReg, r1, r2, st, amt);
      OP_MOVN: word_d = {sf, 2'd0, 1'b1, 2'b00, 3'b101, amt[5:4], imm[15:0], r1};
      OP_MOVZ: word_d = {sf, 2'd2, 1'b1, 2'b00, 3'b101, amt[5:4], imm[15:0], r1};
      OP_MOVK: word_d = {sf, 2'd3, 1'b1, 2'b00, 3'b101, amt[5:4], imm[15:0], r1};
      OP_MOV:  word_d = logic_reg(sf, 3'd2, r1, ZeroReg, r2, st, amt);
      OP_MVN:  word_d = logic_reg(sf, 3'd3, r1, ZeroReg, r2, st, amt);
      OP_MADD: word_d = mul_acc(sf, 1'b0, r1, r2, r3, r4);
      OP_MSUB: word_d = mul_acc(sf, 1'b1, r1, r2, r3, r4);
      OP_MUL:  word_d = mul_acc(sf, 1'b0, r1, r2, r3, ZeroReg);
      OP_MNEG: word_d = mul_acc(sf, 1'b1, r1, r2, r3, ZeroReg);
      OP_B:    word_d = {6'b000101, woff[25:0]};
      OP_B_EQ, OP_B_NE, OP_B_GE, OP_B_LT, OP_B_GT, OP_B_LE, OP_B_AL: begin
        word_d = {BcondTop, woff[18:0], cond};
      end
      OP_BR:   word_d = {BrTop, 6'b000000, r1, 5'b00000};
      OP_LDR_UOFF, OP_STR_UOFF, OP_LDR_PRE, OP_STR_PRE,
      OP_LDR_POST, OP_STR_POST, OP_LDR_ROFF, OP_STR_ROFF: begin
        word_d = {1'b1, sf, 3'b111, 2'b00, (xop[2:1] == 2'b00), 1'b0, !xop[0], xoff,
                  r2, r1};
      end
      OP_LDR_LIT: word_d = {1'b0, sf, 3'b011, 3'b000, woff[18:0], r1};
      OP_INT:     word_d = imm;
      OP_NOP:     word_d = NopWord;
      default:    word_d = '0;
    endcase
  end

  `A64E_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_q, "result register not loaded")
  `A64E_ASSERT_NEXT(a_count_step, advance, count_q == $past(count_q) + CountW'(1),
                    "counter did not step on issue")
  `A64E_ASSERT_NEXT(a_count_hold, !advance, $stable(count_q), "counter moved without issue")
  `A64E_ASSERT_NEXT(a_in_loaded, in_xfer, in_valid_q, "input register not loaded")
  `A64E_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q && $stable(item_q),
                    "stalled input register changed")

endmodule

`default_nettype wire
